[design/lcas_pkg.sv]
`timescale 1ns / 1ps

package lcas_pkg;

    localparam int ROW_W        = 13;
    localparam int GRID_COLS_W  = 8;
    localparam int CFG_DATA_W   = 13;
    localparam int TDATA_W      = 8;

    localparam logic [ROW_W-1:0] MIN_DIM     = 13'd3;
    localparam logic [ROW_W-1:0] ROWS_LIMIT  = 13'd4096;
    localparam logic [ROW_W-1:0] ROWS_RESET  = 13'd150;
    localparam int               COLS_RESET  = 80;

    localparam logic [3:0] BORN_COUNT = 4'd3;
    localparam logic [3:0] KEEP_LOW   = 4'd2;
    localparam logic [3:0] KEEP_HIGH  = 4'd3;

    // register indexes on the config port
    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    // input word kinds
    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic above;
        logic middle;
    } t_line_pair;

    typedef struct packed {
        logic emit;
        logic alive;
        logic last;
    } t_cell_res;

endpackage

[design/lcas_cfg.sv]
`timescale 1ns / 1ps

module lcas_cfg #(
    parameter int MAX_COLS = 128
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_index,
    input  logic [lcas_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [lcas_pkg::ROW_W-1:0]        o_rows,
    output logic [$clog2(MAX_COLS):0]         o_cols,
    output logic                              o_clr
);
    import lcas_pkg::*;

    localparam int CCW = $clog2(MAX_COLS) + 1;
    localparam logic [CCW-1:0] COLS_RST =
        (COLS_RESET > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(COLS_RESET);

    logic [ROW_W-1:0]       r_rows, n_rows;
    logic [CCW-1:0]         r_cols, n_cols;
    logic [ROW_W-1:0]       wr_rows;
    logic [GRID_COLS_W-1:0] wr_cols;

    assign wr_rows = i_cfg_data[ROW_W-1:0];
    assign wr_cols = i_cfg_data[GRID_COLS_W-1:0];

    // saturate on write so the datapath sees in-range sizes only
    always_comb begin
        n_rows = r_rows;
        n_cols = r_cols;
        if (i_cfg_valid && i_cfg_index == REG_GRID_ROWS) begin
            if (wr_rows < MIN_DIM) begin
                n_rows = MIN_DIM;
            end else if (wr_rows > ROWS_LIMIT) begin
                n_rows = ROWS_LIMIT;
            end else begin
                n_rows = wr_rows;
            end
        end
        if (i_cfg_valid && i_cfg_index == REG_GRID_COLS) begin
            if (wr_cols < GRID_COLS_W'(3)) begin
                n_cols = CCW'(3);
            end else if (int'(wr_cols) > MAX_COLS) begin
                n_cols = CCW'(MAX_COLS);
            end else begin
                n_cols = CCW'(wr_cols);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RESET;
            r_cols <= COLS_RST;
        end else begin
            r_rows <= n_rows;
            r_cols <= n_cols;
        end
    end

    assign o_rows = r_rows;
    assign o_cols = r_cols;
    assign o_clr  = i_cfg_valid;

endmodule

[design/lcas_line_buf.sv]
`timescale 1ns / 1ps

module lcas_line_buf #(
    parameter int MAX_COLS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]   i_wr_addr,
    input  lcas_pkg::t_line_pair          i_wr_data,
    input  logic [$clog2(MAX_COLS)-1:0]   i_rd_addr,
    output lcas_pkg::t_line_pair          o_rd_data
);
    import lcas_pkg::*;

    t_line_pair mem [MAX_COLS];
    t_line_pair r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // write-first on an address match (end of frame wraps to column zero)
    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_addr == i_rd_addr) begin
            r_rd <= i_wr_data;
        end else begin
            r_rd <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

[design/lcas_stencil.sv]
`timescale 1ns / 1ps

module lcas_stencil #(
    parameter int MAX_COLS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_opcode,
    input  logic                          i_cell,
    input  logic [lcas_pkg::ROW_W-1:0]    i_rows,
    input  logic [$clog2(MAX_COLS):0]     i_cols,
    input  logic                          i_clr,
    input  lcas_pkg::t_line_pair          i_lines,
    output logic [$clog2(MAX_COLS)-1:0]   o_rd_addr,
    output logic                          o_wr_en,
    output logic [$clog2(MAX_COLS)-1:0]   o_wr_addr,
    output lcas_pkg::t_line_pair          o_wr_data,
    output lcas_pkg::t_cell_res           o_res
);
    import lcas_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int CCW = CW + 1;

    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    r_col, n_col;
    logic [8:0]       r_win, n_win;
    logic [8:0]       shift_win;

    logic       drain, skip, take, v, interior, wrap;
    logic [3:0] nbr;
    logic       centre;

    assign drain = (i_opcode == OP_DRAIN);
    assign skip  = drain && r_row == '0 && r_col == '0;
    assign take  = i_accept && !skip;
    // cells past the frame act as drain words
    assign v     = !drain && r_row < i_rows && i_cell;
    assign wrap  = (CCW'(r_col) + CCW'(1)) == i_cols;

    // window after this word shifts in; the result is taken from it
    assign shift_win = {v, r_win[8:7], i_lines.middle, r_win[5:4], i_lines.above, r_win[2:1]};

    // window bit index is row*3 + col, row 0 oldest, col 0 leftmost
    always_comb begin
        nbr = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                nbr = nbr + 4'(shift_win[k]);
            end
        end
    end

    assign centre   = shift_win[4];
    assign interior = r_row >= ROW_W'(2) && r_row < i_rows && r_col >= CW'(2);

    always_comb begin
        o_res.emit  = r_row >= ROW_W'(2) || (r_row == ROW_W'(1) && r_col != '0);
        o_res.alive = centre;
        o_res.last  = 1'b0;
        if (r_col == '0) begin
            // last column is a border; its value still sits in the window
            o_res.alive = r_win[5];
            o_res.last  = (r_row == i_rows + ROW_W'(1));
        end else if (interior) begin
            if (centre) begin
                o_res.alive = (nbr == KEEP_LOW) || (nbr == KEEP_HIGH);
            end else begin
                o_res.alive = (nbr == BORN_COUNT);
            end
        end
        if (!take) begin
            o_res.emit = 1'b0;
        end
    end

    always_comb begin
        n_win = r_win;
        n_row = r_row;
        n_col = r_col;
        if (i_clr) begin
            n_row = '0;
            n_col = '0;
        end else if (take) begin
            n_win = shift_win;
            if (o_res.last) begin
                n_row = '0;
                n_col = '0;
            end else if (wrap) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_win <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
            r_win <= n_win;
        end
    end

    // line buffer is read one word ahead at the next column
    assign o_rd_addr        = n_col;
    assign o_wr_en          = take;
    assign o_wr_addr        = r_col;
    assign o_wr_data.above  = i_lines.middle;
    assign o_wr_data.middle = v;

endmodule

[design/life_cellular_automaton_stencil_core.sv]
`timescale 1ns / 1ps

// One generation of B3/S23 Life over a raster-order cell stream. One word is
// taken every clock unless a result waits on i_m_tready; the result for a cell
// leaves in the cycle after the word that completes its 3x3 neighbourhood, i.e.
// grid_cols + 1 words later, held in an output register. Border cells pass
// through unchanged. Send grid_cols + 1 drain words after the last cell to
// flush the frame; tlast marks its final cell. The two line buffers are one
// 2-bit wide memory of MAX_COLS words, read one column ahead. A config write
// restarts the frame; grid sizes are saturated to their legal ranges.
module life_cellular_automaton_stencil_core #(
    parameter int MAX_COLS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [lcas_pkg::TDATA_W-1:0]        i_s_tdata,   // [0] cell_value
    input  logic                                i_s_tuser,   // [0] opcode
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [lcas_pkg::TDATA_W-1:0]        o_m_tdata,   // [0] next_cell
    output logic                                o_m_tlast,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_index,
    input  logic [lcas_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import lcas_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    logic [ROW_W-1:0] rows;
    logic [CW:0]      cols;
    logic             clr;
    logic             accept;
    logic [CW-1:0]    rd_addr, wr_addr;
    logic             wr_en;
    t_line_pair       wr_data, lines;
    t_cell_res        res;

    logic r_valid, r_cell, r_last;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = !r_valid || i_m_tready;
    assign accept      = i_s_tvalid && o_s_tready;

    lcas_cfg #(.MAX_COLS(MAX_COLS)) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rows      (rows),
        .o_cols      (cols),
        .o_clr       (clr)
    );

    lcas_line_buf #(.MAX_COLS(MAX_COLS)) u_line_buf (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (lines)
    );

    lcas_stencil #(.MAX_COLS(MAX_COLS)) u_stencil (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_opcode  (i_s_tuser),
        .i_cell    (i_s_tdata[0]),
        .i_rows    (rows),
        .i_cols    (cols),
        .i_clr     (clr),
        .i_lines   (lines),
        .o_rd_addr (rd_addr),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_res     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= res.emit;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && res.emit) begin
            r_cell <= res.alive;
            r_last <= res.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(TDATA_W-1){1'b0}}, r_cell};
    assign o_m_tlast  = r_last;

endmodule

[verif/life_cellular_automaton_stencil_core_tb.sv]
`timescale 1ns / 1ps

module life_cellular_automaton_stencil_core_tb;

    import lcas_pkg::*;

    localparam int MAX_COLS    = 128;
    localparam int SETTLE_CYC  = 8;
    localparam int STALL_LIMIT = 1000;
    localparam int WORD_GOAL   = 600;

    typedef struct packed {
        logic next_cell;
        logic frame_last;
    } t_cell_result;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    i_s_tdata   = '0;    // [0] cell_value
    logic                  i_s_tuser   = 1'b0;  // [0] opcode
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [TDATA_W-1:0]    o_m_tdata;           // [0] next_cell
    logic                  o_m_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic                  i_cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    life_cellular_automaton_stencil_core #(
        .MAX_COLS (MAX_COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    logic [ROW_W-1:0]       rows_reg;
    logic [GRID_COLS_W-1:0] cols_reg;
    logic                   hist_above  [MAX_COLS];
    logic                   hist_middle [MAX_COLS];
    logic [8:0]             nbhd;
    logic [ROW_W-1:0]       cur_row;
    logic [6:0]             cur_col;

    t_cell_result pending_cells[$];
    int           error_count = 0;
    int           quiet_cycles = 0;
    int           frame_words = 0;
    bit           calm = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned grid_h();
        if (rows_reg < MIN_DIM) return 32'(MIN_DIM);
        if (rows_reg > ROWS_LIMIT) return 32'(ROWS_LIMIT);
        return 32'(rows_reg);
    endfunction

    function automatic int unsigned grid_w();
        if (cols_reg < MIN_DIM) return 32'(MIN_DIM);
        if (cols_reg > MAX_COLS) return MAX_COLS;
        return 32'(cols_reg);
    endfunction

    task automatic report_error(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // one accepted word through the B3/S23 stencil
    task automatic life_next(input logic op, input logic val,
                             output logic emit, output t_cell_result res);
        int unsigned rows, cols, r, c, n;
        logic drain, v, above, middle, corner, alive;
        rows  = grid_h();
        cols  = grid_w();
        r     = 32'(cur_row);
        c     = 32'(cur_col) % cols;
        drain = (op == OP_DRAIN);
        emit  = 1'b0;
        res   = '0;
        if (drain && r == 0 && c == 0)
            return;
        v      = (!drain && r < rows) ? val : 1'b0;
        above  = hist_above[c];
        middle = hist_middle[c];
        corner = hist_above[cols-1];
        nbhd   = {v, nbhd[8:7], middle, nbhd[5:4], above, nbhd[2:1]};
        hist_above[c]  = middle;
        hist_middle[c] = v;
        if (r >= 2 || (r == 1 && c >= 1)) begin
            emit = 1'b1;
            if (c == 0) begin
                // emitted cell is in the last column
                res.next_cell  = corner;
                res.frame_last = (r - 2 == rows - 1);
            end else begin
                alive = nbhd[4];
                if (r >= 2 && r + 1 <= rows && c >= 2 && c + 1 <= cols) begin
                    n = $countones(nbhd) - 32'(nbhd[4]);
                    if (alive)
                        alive = (n == KEEP_LOW || n == KEEP_HIGH);
                    else
                        alive = (n == BORN_COUNT);
                end
                res.next_cell = alive;
            end
            if (res.frame_last) begin
                cur_row = '0;
                cur_col = '0;
                return;
            end
        end
        c++;
        if (c >= cols) begin
            c = 0;
            r++;
        end
        cur_row = r[ROW_W-1:0];
        cur_col = c[6:0];
    endtask

    // results are checked before the word accepted at the same edge is predicted
    always @(posedge i_clk) begin : scoreboard
        t_cell_result want;
        t_cell_result got;
        logic         emit_now;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (pending_cells.size() == 0) begin
                    report_error($sformatf("unexpected word, next_cell %0b last %0b",
                                           o_m_tdata[0], o_m_tlast));
                end else begin
                    want = pending_cells.pop_front();
                    if (o_m_tdata[0] !== want.next_cell)
                        report_error($sformatf("next_cell %0b, want %0b",
                                               o_m_tdata[0], want.next_cell));
                    if (o_m_tlast !== want.frame_last)
                        report_error($sformatf("frame_last %0b, want %0b",
                                               o_m_tlast, want.frame_last));
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                life_next(i_s_tuser, i_s_tdata[0], emit_now, got);
                if (emit_now)
                    pending_cells.push_back(got);
            end
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 21);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_word(input logic op, input logic val);
        while (!calm && $urandom_range(99) < 21) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {{(TDATA_W-1){1'b0}}, val};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // always waits for a clock edge so tvalid is not re-driven in this step
    task automatic wait_results();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_cells.size() != 0);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_GRID_ROWS)
            rows_reg = val;
        else
            cols_reg = val[GRID_COLS_W-1:0];
        cur_row = '0;
        cur_col = '0;
    endtask

    // one frame of random cells plus its flush tail; stops early at stop_at
    task automatic run_frame(input int fill_pct, input int hole_pct, input int stop_at);
        int   total, cells, k;
        logic op;
        cells = int'(grid_h() * grid_w());
        total = cells + int'(grid_w()) + 1;
        for (k = 0; k < total && k != stop_at; k++) begin
            if (k == 0)
                op = OP_CELL;
            else if (k < cells)
                op = ($urandom_range(99) < hole_pct) ? OP_DRAIN : OP_CELL;
            else
                op = $urandom_range(1) ? OP_DRAIN : OP_CELL;
            send_word(op, $urandom_range(99) < fill_pct);
            frame_words++;
            if ($urandom_range(99) == 0)
                wait_results();
        end
    endtask

    // reset geometry is 150 x 80; a partial frame checks the column count,
    // and the next register write abandons it
    task automatic test_reset_geometry();
        calm = 1'b1;
        run_frame(50, 3, 170);
        calm = 1'b0;
    endtask

    task automatic test_directed_cases();
        int k;
        write_reg(REG_GRID_COLS, 13'd3);
        write_reg(REG_GRID_ROWS, 13'd3);
        // drain at frame start is dropped
        send_word(OP_DRAIN, 1'b1);
        // center is dead with three neighbors, one neighbor given as a drain
        send_word(OP_CELL, 1'b1);
        send_word(OP_CELL, 1'b0);
        send_word(OP_CELL, 1'b1);
        send_word(OP_DRAIN, 1'b1);
        send_word(OP_CELL, 1'b0);
        send_word(OP_CELL, 1'b1);
        send_word(OP_CELL, 1'b0);
        send_word(OP_CELL, 1'b0);
        send_word(OP_CELL, 1'b0);
        // tail: cell words past the frame count as dead
        send_word(OP_CELL, 1'b1);
        send_word(OP_DRAIN, 1'b0);
        send_word(OP_CELL, 1'b1);
        send_word(OP_DRAIN, 1'b1);
        // live center with two neighbors on the diagonal survives
        for (k = 0; k < 9; k++)
            send_word(OP_CELL, k == 0 || k == 4 || k == 8);
        for (k = 0; k < 4; k++)
            send_word(OP_DRAIN, 1'b0);
    endtask

    task automatic test_size_limits();
        write_reg(REG_GRID_ROWS, 13'd0);
        write_reg(REG_GRID_COLS, 13'd0);
        run_frame(50, 5, -1);
        // columns clamp to the line buffer depth; two rows and 24 words of it are enough
        write_reg(REG_GRID_COLS, 13'd255);
        run_frame(40, 3, 280);
        // upper data bits are dropped on the column register
        write_reg(REG_GRID_ROWS, 13'h1FFF);
        write_reg(REG_GRID_COLS, 13'h1F03);
        run_frame(45, 2, 40);
        write_reg(REG_GRID_ROWS, 13'd5);
    endtask

    task automatic test_random_frames();
        int goal;
        goal = WORD_GOAL;
        while (frame_words < goal) begin
            calm = ($urandom_range(99) < 15);
            if ($urandom_range(99) < 40) begin
                write_reg(REG_GRID_ROWS, CFG_DATA_W'($urandom_range(0, 7)));
                write_reg(REG_GRID_COLS, {5'($urandom), 8'($urandom_range(0, 10))});
            end
            if ($urandom_range(99) < 20)
                send_word(OP_DRAIN, 1'($urandom_range(1)));
            if ($urandom_range(99) < 12) begin
                run_frame(int'($urandom_range(20, 70)), int'($urandom_range(0, 8)),
                          int'($urandom_range(1, 30)));
                write_reg(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(0, 7)));
            end else begin
                run_frame(int'($urandom_range(20, 70)), int'($urandom_range(0, 8)), -1);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        rows_reg = ROWS_RESET;
        cols_reg = GRID_COLS_W'(COLS_RESET);
        nbhd     = '0;
        cur_row  = '0;
        cur_col  = '0;
        for (int i = 0; i < MAX_COLS; i++) begin
            hist_above[i]  = 1'b0;
            hist_middle[i] = 1'b0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_geometry();
        test_directed_cases();
        test_size_limits();
        test_random_frames();
        settle();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
design/lcas_pkg.sv
design/lcas_cfg.sv
design/lcas_line_buf.sv
design/lcas_stencil.sv
design/life_cellular_automaton_stencil_core.sv
verif/life_cellular_automaton_stencil_core_tb.sv
